[src/plist_pkg.sv]
package plist_pkg;

   localparam int CAPACITY   = 16;
   localparam int DUMP_LIMIT = 16;

   localparam int TYPE_W = 4;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 8;
   localparam int ST_W   = 3;
   localparam int LEN_W  = 5;
   localparam int CODE_W = 2;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int DUMP_CAP = (CAPACITY < DUMP_LIMIT) ? CAPACITY : DUMP_LIMIT;

   localparam logic [TYPE_W-1:0] OP_INS_FRONT   = 4'd0;
   localparam logic [TYPE_W-1:0] OP_INS_END     = 4'd1;
   localparam logic [TYPE_W-1:0] OP_INS_AT      = 4'd2;
   localparam logic [TYPE_W-1:0] OP_DEL_FRONT   = 4'd3;
   localparam logic [TYPE_W-1:0] OP_DEL_END     = 4'd4;
   localparam logic [TYPE_W-1:0] OP_DEL_AT      = 4'd5;
   localparam logic [TYPE_W-1:0] OP_DEL_VALUE   = 4'd6;
   localparam logic [TYPE_W-1:0] OP_COMPARE     = 4'd7;
   localparam logic [TYPE_W-1:0] OP_DUMP        = 4'd8;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;

   localparam logic [CODE_W-1:0] CMP_EQUAL      = 2'd0;
   localparam logic [CODE_W-1:0] CMP_FIRST_GT   = 2'd1;
   localparam logic [CODE_W-1:0] CMP_LAST_GT    = 2'd2;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] value_out;
      logic signed [VAL_W-1:0] second_value;
      logic [LEN_W-1:0]        removed_count;
      logic [CODE_W-1:0]       compare_code;
      logic [LEN_W-1:0]        list_length;
      logic                    last_item;
   } rsp_beat_type;

endpackage

[src/plist_channels.sv]
interface plist_req_if;
   import plist_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [TYPE_W-1:0]       req_type;
   logic signed [VAL_W-1:0] item_value;
   logic [POS_W-1:0]        slot_position;

   modport source (output valid, req_type, item_value, slot_position, input ready);
   modport sink (input valid, req_type, item_value, slot_position, output ready);
endinterface

interface plist_rsp_if;
   import plist_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ST_W-1:0]         status;
   logic signed [VAL_W-1:0] value_out;
   logic signed [VAL_W-1:0] second_value;
   logic [LEN_W-1:0]        removed_count;
   logic [CODE_W-1:0]       compare_code;
   logic [LEN_W-1:0]        list_length;
   logic                    last_item;

   modport source (output valid, status, value_out, second_value, removed_count,
                   compare_code, list_length, last_item, input ready);
   modport sink (input valid, status, value_out, second_value, removed_count,
                 compare_code, list_length, last_item, output ready);
endinterface

[src/positional_list_engine.sv]
// positional list engine: an ordered list of up to CAPACITY signed 32-bit
// entries kept in a single-port-write, single-port-read memory with a count.
// req_bus carries one request beat (req_type, item_value, slot_position);
// it is taken only while the engine is idle, one request at a time.
// rsp_bus returns one beat per request, or one beat per entry for a dump
// (at most 16), with last_item set on the final beat.
// per request, from accept to the response handed to the output stage:
//   ins_front/ins_at move the entries from index i on up by one, then
//   write the new entry at i; ins_end writes at the end; del_front/del_at
//   move the entries after i down by one; del_end and rejects go straight
//   to the response; del_value compacts the list; compare_ends reads both
//   ends; dump reads and hands out each entry in turn.
// shifts and compaction move one entry per cycle through the memory read port.
// results leave through a one-beat output register, so the engine goes on
// with its work while a beat waits; a stalled receiver holds the engine
// only when it has a further beat to hand over.
// reset is synchronous and active high: it empties the list and drops any
// pending beat; memory contents are not cleared.
module positional_list_engine (
   input  logic        clock,
   input  logic        reset,
   plist_req_if.sink   req_bus,
   plist_rsp_if.source rsp_bus
);
   import plist_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MOVE     = 3'd1;
   localparam logic [2:0] S_PUT      = 3'd2;
   localparam logic [2:0] S_RESP     = 3'd3;
   localparam logic [2:0] S_CMP_A    = 3'd4;
   localparam logic [2:0] S_CMP_B    = 3'd5;
   localparam logic [2:0] S_DUMP_RD  = 3'd6;
   localparam logic [2:0] S_DUMP_OUT = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [TYPE_W-1:0]       op_ff, op_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic signed [VAL_W-1:0] v1_ff, v1_in;
   logic signed [VAL_W-1:0] v2_ff, v2_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        rp_ff, rp_in;
   logic [IDX_W-1:0]        pend_src_ff, pend_src_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        w_ff, w_in;
   logic [CNT_W-1:0]        removed_ff, removed_in;
   logic                    pend_ff, pend_in;
   logic [ST_W-1:0]         st_ff, st_in;
   logic [CODE_W-1:0]       code_ff, code_in;

   logic signed [VAL_W-1:0] mem [CAPACITY];
   logic signed [VAL_W-1:0] rd_data_ff;
   logic                    rd_en, wr_en;
   logic [IDX_W-1:0]        rd_addr, wr_addr;
   logic signed [VAL_W-1:0] wr_data;

   logic                    push, slot_free, accept;
   rsp_beat_type            push_beat;

   logic                    is_full, is_empty, is_ins, pos_ok_ins, pos_ok_del;
   logic [CMP_W-1:0]        pos_ext, cnt_ext, pos_m1;
   logic [IDX_W-1:0]        pos_idx, ins_idx, del_idx;
   logic [CNT_W-1:0]        count_m1;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign count_m1   = count_ff - CNT_W'(1);
   assign pos_ext    = CMP_W'(req_bus.slot_position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign pos_idx    = pos_m1[IDX_W-1:0];
   assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
   assign pos_ok_del = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign is_ins     = (op_ff == OP_INS_FRONT) || (op_ff == OP_INS_END) ||
                       (op_ff == OP_INS_AT);

   always_comb begin
      ins_idx = '0;
      if (req_bus.req_type == OP_INS_END) begin
         ins_idx = count_ff[IDX_W-1:0];
      end else if (req_bus.req_type == OP_INS_AT) begin
         ins_idx = pos_idx;
      end
      del_idx = (req_bus.req_type == OP_DEL_AT) ? pos_idx : '0;
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      v1_in       = v1_ff;
      v2_in       = v2_ff;
      idx_in      = idx_ff;
      rp_in       = rp_ff;
      pend_src_in = pend_src_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      w_in        = w_ff;
      removed_in  = removed_ff;
      pend_in     = pend_ff;
      st_in       = st_ff;
      code_in     = code_ff;
      rd_en       = 1'b0;
      rd_addr     = rp_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = val_ff;
      push        = 1'b0;

      push_beat.status        = st_ff;
      push_beat.value_out     = v1_ff;
      push_beat.second_value  = v2_ff;
      push_beat.removed_count = LEN_W'(removed_ff);
      push_beat.compare_code  = code_ff;
      push_beat.list_length   = LEN_W'(count_ff);
      push_beat.last_item     = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in      = req_bus.req_type;
               val_in     = req_bus.item_value;
               st_in      = ST_OK;
               v1_in      = '0;
               v2_in      = '0;
               removed_in = '0;
               code_in    = CMP_EQUAL;
               pend_in    = 1'b0;
               w_in       = '0;
               state_in   = S_RESP;
               case (req_bus.req_type)
                  OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
                     if (is_full) begin
                        st_in = ST_FULL;
                     end else if (req_bus.req_type == OP_INS_AT && !pos_ok_ins) begin
                        st_in = ST_BAD_POS;
                     end else begin
                        idx_in   = ins_idx;
                        rem_in   = count_ff - CNT_W'(ins_idx);
                        rp_in    = count_m1[IDX_W-1:0];
                        state_in = S_MOVE;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_AT: begin
                     if (is_empty) begin
                        st_in = ST_EMPTY;
                     end else if (req_bus.req_type == OP_DEL_AT && !pos_ok_del) begin
                        st_in = ST_BAD_POS;
                     end else begin
                        rem_in   = count_m1 - CNT_W'(del_idx);
                        rp_in    = del_idx + IDX_W'(1);
                        state_in = S_MOVE;
                     end
                  end
                  OP_DEL_END: begin
                     if (is_empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        count_in = count_m1;
                     end
                  end
                  OP_DEL_VALUE: begin
                     if (is_empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        rem_in   = count_ff;
                        rp_in    = '0;
                        state_in = S_MOVE;
                     end
                  end
                  OP_COMPARE: begin
                     if (is_empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_CMP_A;
                     end
                  end
                  OP_DUMP: begin
                     if (is_empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        rp_in    = '0;
                        rem_in   = (count_ff < CNT_W'(DUMP_CAP)) ? count_ff : CNT_W'(DUMP_CAP);
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_MOVE: begin
            // write back the entry read last cycle while the next one is read
            if (pend_ff) begin
               wr_data = rd_data_ff;
               if (is_ins) begin
                  wr_en   = 1'b1;
                  wr_addr = pend_src_ff + IDX_W'(1);
               end else if (op_ff == OP_DEL_VALUE) begin
                  if (rd_data_ff != val_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = w_ff[IDX_W-1:0];
                     w_in    = w_ff + CNT_W'(1);
                  end
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pend_src_ff - IDX_W'(1);
               end
            end
            if (rem_ff != '0) begin
               rd_en       = 1'b1;
               rd_addr     = rp_ff;
               pend_src_in = rp_ff;
               rp_in       = is_ins ? rp_ff - IDX_W'(1) : rp_ff + IDX_W'(1);
               rem_in      = rem_ff - CNT_W'(1);
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff && rem_ff == '0) begin
               if (is_ins) begin
                  state_in = S_PUT;
               end else if (op_ff == OP_DEL_VALUE) begin
                  count_in   = w_ff;
                  removed_in = count_ff - w_ff;
                  st_in      = (count_ff == w_ff) ? ST_NOT_FOUND : ST_OK;
                  state_in   = S_RESP;
               end else begin
                  count_in = count_m1;
                  state_in = S_RESP;
               end
            end
         end

         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = val_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESP;
         end

         S_RESP: begin
            if (slot_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_CMP_A: begin
            v1_in    = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = count_m1[IDX_W-1:0];
            state_in = S_CMP_B;
         end

         S_CMP_B: begin
            v2_in = rd_data_ff;
            if (v1_ff > rd_data_ff) begin
               code_in = CMP_FIRST_GT;
            end else if (v1_ff < rd_data_ff) begin
               code_in = CMP_LAST_GT;
            end else begin
               code_in = CMP_EQUAL;
            end
            state_in = S_RESP;
         end

         S_DUMP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = rp_ff;
            state_in = S_DUMP_OUT;
         end

         S_DUMP_OUT: begin
            push_beat.status        = ST_OK;
            push_beat.value_out     = rd_data_ff;
            push_beat.second_value  = '0;
            push_beat.removed_count = '0;
            push_beat.compare_code  = CMP_EQUAL;
            push_beat.last_item     = (rem_ff == CNT_W'(1));
            if (slot_free) begin
               push     = 1'b1;
               rem_in   = rem_ff - CNT_W'(1);
               rp_in    = rp_ff + IDX_W'(1);
               state_in = (rem_ff == CNT_W'(1)) ? S_IDLE : S_DUMP_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff       <= op_in;
      val_ff      <= val_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      idx_ff      <= idx_in;
      rp_ff       <= rp_in;
      pend_src_ff <= pend_src_in;
      rem_ff      <= rem_in;
      w_ff        <= w_in;
      removed_ff  <= removed_in;
      st_ff       <= st_in;
      code_ff     <= code_in;
   end

   plist_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .slot_free (slot_free),
      .rsp_bus   (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of one entry in one cycle");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list by one");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> slot_free)
      else $error("beat pushed into a full output stage");

   a_idle_no_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!wr_en && !pend_ff))
      else $error("memory activity while idle");
`endif

endmodule

[src/plist_rsp_reg.sv]
module plist_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  plist_pkg::rsp_beat_type push_beat,
   output logic                   slot_free,
   plist_rsp_if.source            rsp_bus
);
   import plist_pkg::*;

   logic         valid_ff, valid_in;
   rsp_beat_type beat_ff, beat_in;

   assign slot_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (slot_free) begin
         valid_in = push;
         if (push) begin
            beat_in = push_beat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.status        = beat_ff.status;
   assign rsp_bus.value_out     = beat_ff.value_out;
   assign rsp_bus.second_value  = beat_ff.second_value;
   assign rsp_bus.removed_count = beat_ff.removed_count;
   assign rsp_bus.compare_code  = beat_ff.compare_code;
   assign rsp_bus.list_length   = beat_ff.list_length;
   assign rsp_bus.last_item     = beat_ff.last_item;

endmodule

[tb/sv/positional_list_engine_tb.sv]
module positional_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import plist_pkg::*;

   localparam int TOTAL_ITEMS    = 410;
   localparam int DIRECTED_COUNT = 24;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 60;
   localparam int PRINT_LIMIT    = 40;

   localparam logic [TYPE_W-1:0] OP_UNUSED_LOW = 4'd9;
   localparam logic [TYPE_W-1:0] OP_UNUSED_TOP = 4'd15;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   localparam rsp_beat_type EMPTY_REPLY =
      '{ST_EMPTY, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd0, 1'b1};

   typedef struct packed {
      logic [TYPE_W-1:0]       op;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        pos;
      logic                    pinned;
      rsp_beat_type            want;
   } directed_row_type;

   logic clock;
   logic reset;

   plist_req_if req_ch ();
   plist_rsp_if rsp_ch ();

   positional_list_engine uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // shadow copy of the list
   logic signed [VAL_W-1:0] mirror_entries [CAPACITY];
   int unsigned             mirror_len = 0;

   rsp_beat_type awaited_beats [$];
   int unsigned  mismatch_count = 0;
   int unsigned  beats_checked  = 0;
   int unsigned  requests_sent  = 0;
   int unsigned  idle_cycles    = 0;
   bit           sender_steady  = 1'b0;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{OP_DEL_FRONT,  32'sd0,  8'd0,   1'b1, EMPTY_REPLY},
      '{OP_DEL_END,    -32'sd1, 8'd0,   1'b1, EMPTY_REPLY},
      '{OP_DEL_AT,     32'sd0,  8'd1,   1'b1, EMPTY_REPLY},
      '{OP_DEL_VALUE,  32'sd0,  8'd0,   1'b1, EMPTY_REPLY},
      '{OP_COMPARE,    32'sd0,  8'd0,   1'b1, EMPTY_REPLY},
      '{OP_DUMP,       32'sd0,  8'd0,   1'b1, EMPTY_REPLY},
      '{OP_UNUSED_TOP, -32'sd1, 8'd255, 1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd0, 1'b1}},
      '{OP_INS_AT,     32'sd9,  8'd0,   1'b1,
        '{ST_BAD_POS, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd0, 1'b1}},
      '{OP_INS_AT,     32'sd9,  8'd2,   1'b1,
        '{ST_BAD_POS, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd0, 1'b1}},
      '{OP_INS_AT,     VAL_MIN, 8'd1,   1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd1, 1'b1}},
      '{OP_INS_END,    VAL_MAX, 8'd0,   1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd2, 1'b1}},
      '{OP_COMPARE,    32'sd0,  8'd0,   1'b1,
        '{ST_OK, VAL_MIN, VAL_MAX, 5'd0, CMP_LAST_GT, 5'd2, 1'b1}},
      '{OP_INS_FRONT,  VAL_MAX, 8'd0,   1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd3, 1'b1}},
      '{OP_COMPARE,    32'sd0,  8'd0,   1'b1,
        '{ST_OK, VAL_MAX, VAL_MAX, 5'd0, CMP_EQUAL, 5'd3, 1'b1}},
      '{OP_INS_AT,     32'sd5,  8'd4,   1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd4, 1'b1}},
      '{OP_COMPARE,    32'sd0,  8'd0,   1'b1,
        '{ST_OK, VAL_MAX, 32'sd5, 5'd0, CMP_FIRST_GT, 5'd4, 1'b1}},
      '{OP_INS_AT,     32'sd1,  8'd255, 1'b1,
        '{ST_BAD_POS, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd4, 1'b1}},
      '{OP_DEL_AT,     32'sd0,  8'd0,   1'b1,
        '{ST_BAD_POS, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd4, 1'b1}},
      '{OP_DEL_AT,     32'sd0,  8'd5,   1'b1,
        '{ST_BAD_POS, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd4, 1'b1}},
      '{OP_DEL_VALUE,  32'sd12345, 8'd0, 1'b1,
        '{ST_NOT_FOUND, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd4, 1'b1}},
      '{OP_DEL_VALUE,  VAL_MAX, 8'd0,   1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd2, CMP_EQUAL, 5'd2, 1'b1}},
      '{OP_DUMP,       32'sd0,  8'd0,   1'b0, '0},
      '{OP_DEL_AT,     32'sd0,  8'd2,   1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd1, 1'b1}},
      '{OP_DEL_END,    32'sd0,  8'd0,   1'b1,
        '{ST_OK, 32'sd0, 32'sd0, 5'd0, CMP_EQUAL, 5'd0, 1'b1}}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at %0t ns, beat %0d: %s", $realtime, beats_checked, what);
   endtask

   function automatic void put_entry(input int unsigned idx,
                                     input logic signed [VAL_W-1:0] value);
      int unsigned i;
      for (i = mirror_len; i > idx; i--)
         mirror_entries[i] = mirror_entries[i - 1];
      mirror_entries[idx] = value;
      mirror_len++;
   endfunction

   function automatic void take_entry(input int unsigned idx);
      int unsigned i;
      for (i = idx; i + 1 < mirror_len; i++)
         mirror_entries[i] = mirror_entries[i + 1];
      mirror_len--;
   endfunction

   // updates the shadow list and queues the beats the request should return
   function automatic void apply_list_op(input logic [TYPE_W-1:0] op,
                                         input logic signed [VAL_W-1:0] value,
                                         input logic [POS_W-1:0] pos);
      rsp_beat_type beat;
      int unsigned  keep, shown, i;
      beat = '0;
      beat.last_item = 1'b1;
      case (op)
         OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
            if (mirror_len >= CAPACITY) beat.status = ST_FULL;
            else if (op == OP_INS_FRONT) put_entry(0, value);
            else if (op == OP_INS_END) put_entry(mirror_len, value);
            else if (pos == 0 || pos > mirror_len + 1) beat.status = ST_BAD_POS;
            else put_entry(pos - 1, value);
         end
         OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
            if (mirror_len == 0) beat.status = ST_EMPTY;
            else if (op == OP_DEL_FRONT) take_entry(0);
            else if (op == OP_DEL_END) mirror_len--;
            else if (pos == 0 || pos > mirror_len) beat.status = ST_BAD_POS;
            else take_entry(pos - 1);
         end
         OP_DEL_VALUE: begin
            if (mirror_len == 0) begin
               beat.status = ST_EMPTY;
            end else begin
               keep = 0;
               for (i = 0; i < mirror_len; i++)
                  if (mirror_entries[i] != value) begin
                     mirror_entries[keep] = mirror_entries[i];
                     keep++;
                  end
               beat.removed_count = LEN_W'(mirror_len - keep);
               mirror_len = keep;
               if (beat.removed_count == 0) beat.status = ST_NOT_FOUND;
            end
         end
         OP_COMPARE: begin
            if (mirror_len == 0) begin
               beat.status = ST_EMPTY;
            end else begin
               beat.value_out    = mirror_entries[0];
               beat.second_value = mirror_entries[mirror_len - 1];
               if (beat.value_out > beat.second_value) beat.compare_code = CMP_FIRST_GT;
               else if (beat.value_out < beat.second_value) beat.compare_code = CMP_LAST_GT;
               else beat.compare_code = CMP_EQUAL;
            end
         end
         OP_DUMP: begin
            if (mirror_len == 0) begin
               beat.status = ST_EMPTY;
            end else begin
               shown = (mirror_len < DUMP_LIMIT) ? mirror_len : DUMP_LIMIT;
               for (i = 0; i < shown; i++) begin
                  beat.value_out   = mirror_entries[i];
                  beat.list_length = LEN_W'(mirror_len);
                  beat.last_item   = (i + 1 == shown);
                  awaited_beats.push_back(beat);
               end
               return;
            end
         end
         default: ;
      endcase
      beat.list_length = LEN_W'(mirror_len);
      awaited_beats.push_back(beat);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2, 3, 4: return 32'($urandom_range(0, 4)) - 32'sd2;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input int unsigned top);
      if (top == 0 || $urandom_range(0, 9) < 2) return POS_W'($urandom_range(0, 255));
      return POS_W'($urandom_range(1, top));
   endfunction

   function automatic logic signed [VAL_W-1:0] existing_value();
      if (mirror_len == 0) return pick_value();
      return mirror_entries[$urandom_range(0, mirror_len - 1)];
   endfunction

   task automatic send_request(input logic [TYPE_W-1:0] op,
                               input logic signed [VAL_W-1:0] value,
                               input logic [POS_W-1:0] pos,
                               input logic pinned,
                               input rsp_beat_type want);
      int unsigned gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.req_type      <= op;
      req_ch.item_value    <= value;
      req_ch.slot_position <= pos;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      apply_list_op(op, value, pos);
      if (pinned) begin
         void'(awaited_beats.pop_back());
         awaited_beats.push_back(want);
      end
      if (op <= OP_DUMP) requests_sent++;
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited_beats.size() != 0) @(posedge clock);
   endtask

   task automatic fill_list();
      logic [TYPE_W-1:0] op;
      while (mirror_len < CAPACITY) begin
         case ($urandom_range(0, 2))
            0: op = OP_INS_FRONT;
            1: op = OP_INS_END;
            default: op = OP_INS_AT;
         endcase
         send_request(op, pick_value(), pick_position(mirror_len + 1), 1'b0, '0);
      end
      // full list: two inserts that must be refused, then a long dump and a compare
      send_request(OP_INS_AT, pick_value(), pick_position(CAPACITY + 1), 1'b0, '0);
      send_request(OP_INS_FRONT, pick_value(), pick_position(0), 1'b0, '0);
      send_request(OP_DUMP, pick_value(), pick_position(0), 1'b0, '0);
      send_request(OP_COMPARE, pick_value(), pick_position(0), 1'b0, '0);
   endtask

   task automatic drain_list();
      logic [TYPE_W-1:0]       op;
      logic signed [VAL_W-1:0] value;
      while (mirror_len != 0) begin
         value = pick_value();
         case ($urandom_range(0, 3))
            0: op = OP_DEL_FRONT;
            1: op = OP_DEL_END;
            2: op = OP_DEL_AT;
            default: begin
               op    = OP_DEL_VALUE;
               value = existing_value();
            end
         endcase
         send_request(op, value, pick_position(mirror_len), 1'b0, '0);
      end
      send_request(OP_DEL_AT, pick_value(), pick_position(1), 1'b0, '0);
      send_request(OP_DUMP, pick_value(), pick_position(0), 1'b0, '0);
   endtask

   task automatic mix_list(input int unsigned count);
      logic [TYPE_W-1:0]       op;
      logic signed [VAL_W-1:0] value;
      int unsigned             roll, k;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) op = OP_INS_FRONT;
         else if (roll < 24) op = OP_INS_END;
         else if (roll < 38) op = OP_INS_AT;
         else if (roll < 46) op = OP_DEL_FRONT;
         else if (roll < 54) op = OP_DEL_END;
         else if (roll < 66) op = OP_DEL_AT;
         else if (roll < 76) op = OP_DEL_VALUE;
         else if (roll < 84) op = OP_COMPARE;
         else if (roll < 94) op = OP_DUMP;
         else op = TYPE_W'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_TOP));
         value = (op == OP_DEL_VALUE && $urandom_range(0, 9) < 6) ?
                 existing_value() : pick_value();
         send_request(op, value,
                      pick_position((op == OP_INS_AT) ? mirror_len + 1 : mirror_len),
                      1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_beat_type seen, want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.status        = rsp_ch.status;
            seen.value_out     = rsp_ch.value_out;
            seen.second_value  = rsp_ch.second_value;
            seen.removed_count = rsp_ch.removed_count;
            seen.compare_code  = rsp_ch.compare_code;
            seen.list_length   = rsp_ch.list_length;
            seen.last_item     = rsp_ch.last_item;
            if (awaited_beats.size() == 0) begin
               report_mismatch("result beat with nothing awaited");
            end else begin
               want = awaited_beats.pop_front();
               if (seen.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            seen.status, want.status));
               if (seen.value_out !== want.value_out)
                  report_mismatch($sformatf("value_out %h, want %h",
                                            seen.value_out, want.value_out));
               if (seen.second_value !== want.second_value)
                  report_mismatch($sformatf("second_value %h, want %h",
                                            seen.second_value, want.second_value));
               if (seen.removed_count !== want.removed_count)
                  report_mismatch($sformatf("removed_count %0d, want %0d",
                                            seen.removed_count, want.removed_count));
               if (seen.compare_code !== want.compare_code)
                  report_mismatch($sformatf("compare_code %0d, want %0d",
                                            seen.compare_code, want.compare_code));
               if (seen.list_length !== want.list_length)
                  report_mismatch($sformatf("list_length %0d, want %0d",
                                            seen.list_length, want.list_length));
               if (seen.last_item !== want.last_item)
                  report_mismatch($sformatf("last_item %0d, want %0d",
                                            seen.last_item, want.last_item));
            end
            beats_checked++;
         end
      end
   end

   initial begin : rsp_pacing
      int unsigned run, stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned row;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= OP_INS_FRONT;
      req_ch.item_value    <= '0;
      req_ch.slot_position <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_COUNT; row++)
         send_request(directed_rows[row].op, directed_rows[row].value,
                      directed_rows[row].pos, directed_rows[row].pinned,
                      directed_rows[row].want);
      hold_until_drained();

      fill_list();
      hold_until_drained();
      while (requests_sent < TOTAL_ITEMS) begin
         sender_steady = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: fill_list();
            1: drain_list();
            default: mix_list(30);
         endcase
         if ($urandom_range(0, 2) == 0) hold_until_drained();
      end
      sender_steady = 1'b0;

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_beats.size() != 0)
         report_mismatch($sformatf("%0d result beats never arrived", awaited_beats.size()));
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
